// File: src/sgre_pkg.sv
// Package for the strike glyph row extractor: sizes, field codes and
// register indexes. No dependencies.
package sgre_pkg;

  localparam int MAX_GLYPHS      = 256;
  localparam int MAX_ROW_BYTES   = 256;
  localparam int MAX_ROWS        = 32;
  localparam int MAX_GLYPH_WIDTH = 32;

  localparam int TABLE_DEPTH  = MAX_GLYPHS + 1;
  localparam int STRIKE_DEPTH = MAX_ROW_BYTES * MAX_ROWS;
  localparam int TBL_AW       = $clog2(TABLE_DEPTH);
  localparam int STRIKE_AW    = $clog2(STRIKE_DEPTH);

  // bytes read per row: widest glyph plus up to 7 bits of lead-in
  localparam int FETCH_BYTES = (MAX_GLYPH_WIDTH + 7 + 7) / 8;
  localparam int WIN_W       = FETCH_BYTES * 8;
  localparam int FETCH_CW    = $clog2(FETCH_BYTES + 1);

  typedef logic [1:0] status_t;
  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_BAD_INDEX = 2'd1;
  localparam status_t STAT_EXCEEDS   = 2'd2;
  localparam status_t STAT_TOO_WIDE  = 2'd3;

  typedef logic [1:0] req_t;
  localparam req_t REQ_WR_OFFSET = 2'd0;
  localparam req_t REQ_WR_STRIKE = 2'd1;
  localparam req_t REQ_GLYPH     = 2'd2;
  localparam req_t REQ_NOP       = 2'd3;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_ROW_BYTES     = 2'd0;
  localparam reg_idx_t REG_ROW_COUNT     = 2'd1;
  localparam reg_idx_t REG_GLYPH_COUNT   = 2'd2;
  localparam reg_idx_t REG_DEFAULT_GLYPH = 2'd3;

endpackage

// File: src/strike_glyph_row_extractor.sv
// Strike glyph row extractor: offset table and strike memories, config
// registers and the byte-fetch sequencer. Depends on sgre_pkg.
//
// Timing: a write is stored at the clock edge that accepts it; a bad index is presented
// in the cycle after accept. A row or width fault is presented after the two table reads
// and the checks (TRD0, TRD1, TRD2, CHECK). A good glyph then loops per row through FETCH,
// five registered byte reads on the strike read port, and OUT, which presents the row and
// holds it while out_stall is high. The input stays stalled until the last row leaves, so
// no new request is taken before the glyph is done. Reset: sequencer to idle, registers
// to row_bytes 1, row_count 1, glyph_count 1, default_glyph 63; memories undefined.
module strike_glyph_row_extractor (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sgre_pkg::req_t        req_type,
  input  logic [12:0]           load_addr,
  input  logic [15:0]           load_value,
  input  logic [8:0]            glyph_num,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           row_bits,
  output logic [5:0]            glyph_width,
  output logic [4:0]            row_number,
  output logic                  last,
  output sgre_pkg::status_t     status,
  // config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import sgre_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TRD0  = 3'd1;
  localparam logic [2:0] ST_TRD1  = 3'd2;
  localparam logic [2:0] ST_TRD2  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_FETCH = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  // config registers
  logic [8:0] row_bytes;
  logic [5:0] row_count;
  logic [8:0] glyph_count;
  logic [7:0] default_glyph;

  logic [2:0]           state;
  logic [TBL_AW-1:0]    real_idx;
  logic [15:0]          start_off;
  logic [15:0]          width;
  logic [STRIKE_AW-1:0] row_addr;
  logic [4:0]           row_y;
  logic [FETCH_CW-1:0]  issue_cnt;
  logic                 pending;
  logic [WIN_W-1:0]     window;

  logic [15:0] tbl_mem [TABLE_DEPTH];
  logic [7:0]  strike_mem [STRIKE_DEPTH];
  logic [15:0] tbl_rd_data;
  logic [7:0]  st_rd_data;

  logic [TBL_AW-1:0]    tbl_rd_addr;
  logic [STRIKE_AW-1:0] st_rd_addr;
  logic                 in_accept;
  logic                 cfg_write;
  logic [8:0]           count_eff;
  logic [8:0]           rb_eff;
  logic [5:0]           rows_eff;
  logic                 bad_index;
  logic [TBL_AW-1:0]    real_sel;
  logic [16:0]          end_bit;
  logic [WIN_W-1:0]     win_full;
  logic [WIN_W-1:0]     win_aligned;
  logic [31:0]          row_mask;
  logic                 row_last;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = (state == ST_OUT);

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_ROW_BYTES:     prdata = 32'(row_bytes);
      REG_ROW_COUNT:     prdata = 32'(row_count);
      REG_GLYPH_COUNT:   prdata = 32'(glyph_count);
      REG_DEFAULT_GLYPH: prdata = 32'(default_glyph);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes     <= 9'd1;
      row_count     <= 6'd1;
      glyph_count   <= 9'd1;
      default_glyph <= 8'd63;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_ROW_BYTES:     row_bytes     <= pwdata[8:0];
        REG_ROW_COUNT:     row_count     <= pwdata[5:0];
        REG_GLYPH_COUNT:   glyph_count   <= pwdata[8:0];
        REG_DEFAULT_GLYPH: default_glyph <= pwdata[7:0];
      endcase
    end
  end

  // clamped register values
  assign count_eff = (glyph_count > 9'(MAX_GLYPHS)) ? 9'(MAX_GLYPHS) : glyph_count;
  assign rb_eff    = (row_bytes > 9'(MAX_ROW_BYTES)) ? 9'(MAX_ROW_BYTES) : row_bytes;
  always_comb begin
    if (row_count > 6'(MAX_ROWS)) rows_eff = 6'(MAX_ROWS);
    else if (row_count == 6'd0)   rows_eff = 6'd1;
    else                          rows_eff = row_count;
  end

  assign bad_index = (glyph_num > count_eff) ||
                     ((glyph_num == 9'd0) && ({1'b0, default_glyph} >= count_eff));
  assign real_sel  = (glyph_num == 9'd0) ? TBL_AW'(default_glyph)
                                         : TBL_AW'(glyph_num - 9'd1);

  // memories
  assign tbl_rd_addr = (state == ST_TRD0) ? real_idx : real_idx + TBL_AW'(1);
  assign st_rd_addr  = row_addr + STRIKE_AW'(issue_cnt);

  always_ff @(posedge clk) begin
    if (in_accept && (req_type == REQ_WR_OFFSET) && ({1'b0, load_addr} < 14'(TABLE_DEPTH)))
      tbl_mem[load_addr[TBL_AW-1:0]] <= load_value;
    tbl_rd_data <= tbl_mem[tbl_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_accept && (req_type == REQ_WR_STRIKE) && ({1'b0, load_addr} < 14'(STRIKE_DEPTH)))
      strike_mem[load_addr[STRIKE_AW-1:0]] <= load_value[7:0];
    st_rd_data <= strike_mem[st_rd_addr];
  end

  // row assembly: bytes in read order, drop the lead-in bits, keep width bits
  assign end_bit     = {1'b0, start_off} + {1'b0, width};
  assign win_full    = {window[WIN_W-9:0], st_rd_data};
  assign win_aligned = win_full << start_off[2:0];
  assign row_mask    = ~(32'hFFFF_FFFF >> width[5:0]);
  assign row_last    = (({1'b0, row_y} + 6'd1) == rows_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= 1'b0;
      issue_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept && (req_type == REQ_GLYPH)) begin
            if (bad_index) begin
              row_bits    <= 32'd0;
              glyph_width <= 6'd0;
              row_number  <= 5'd0;
              last        <= 1'b1;
              status      <= STAT_BAD_INDEX;
              state       <= ST_OUT;
            end else begin
              real_idx <= real_sel;
              state    <= ST_TRD0;
            end
          end
        end
        ST_TRD0: state <= ST_TRD1;
        ST_TRD1: begin
          start_off <= tbl_rd_data;
          state     <= ST_TRD2;
        end
        ST_TRD2: begin
          width <= tbl_rd_data - start_off;
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (end_bit > 17'({rb_eff, 3'b000})) begin
            row_bits    <= 32'd0;
            glyph_width <= 6'd0;
            row_number  <= 5'd0;
            last        <= 1'b1;
            status      <= STAT_EXCEEDS;
            state       <= ST_OUT;
          end else if (width > 16'(MAX_GLYPH_WIDTH)) begin
            row_bits    <= 32'd0;
            glyph_width <= 6'd0;
            row_number  <= 5'd0;
            last        <= 1'b1;
            status      <= STAT_TOO_WIDE;
            state       <= ST_OUT;
          end else begin
            row_addr  <= STRIKE_AW'(start_off[15:3]);
            row_y     <= 5'd0;
            issue_cnt <= '0;
            pending   <= 1'b0;
            state     <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          if (pending) window <= win_full;
          if (issue_cnt != FETCH_CW'(FETCH_BYTES)) begin
            issue_cnt <= issue_cnt + FETCH_CW'(1);
            pending   <= 1'b1;
          end else begin
            // last byte of the row lands this cycle
            row_bits    <= win_aligned[WIN_W-1 -: 32] & row_mask;
            glyph_width <= width[5:0];
            row_number  <= row_y;
            last        <= row_last;
            status      <= STAT_OK;
            pending     <= 1'b0;
            state       <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            if (last) begin
              state <= ST_IDLE;
            end else begin
              row_y     <= row_y + 5'd1;
              row_addr  <= row_addr + STRIKE_AW'(rb_eff);
              issue_cnt <= '0;
              state     <= ST_FETCH;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("result presented while input side open");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STAT_OK)) |-> (last && (row_bits == 32'd0)))
    else $error("error result not single");

  a_width_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STAT_OK)) |-> (glyph_width <= 6'(MAX_GLYPH_WIDTH)))
    else $error("glyph width beyond limit");

  a_row_advance: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> (state == ST_FETCH && issue_cnt == '0))
    else $error("row loop did not restart fetch");

  a_fetch_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> (issue_cnt <= FETCH_CW'(FETCH_BYTES)))
    else $error("byte issue count overrun");

endmodule
